@@ src/rhb_pkg.sv @@
// Package for the range histogram binner: sizes, register indexes and
// shared types. No dependencies.
package rhb_pkg;
    localparam int MAX_BINS     = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COUNT_WIDTH  = 32;
    localparam int IDX_W        = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int BC_W         = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int DIV_W        = SAMPLE_WIDTH + BC_W;
    localparam int STEP_W       = $clog2(IDX_W + 1);

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT  = 2'd2;

    typedef struct packed {
        logic                    start;
        logic [DIV_W-1:0]        dividend;
        logic [SAMPLE_WIDTH-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] quotient;
    } t_div_rsp;
endpackage

@@ src/rhb_in_if.sv @@
// Sample channel interface: valid, ready and sample payload.
// Depends on rhb_pkg.
interface rhb_in_if import rhb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    last_sample;
    modport source (output valid, sample, last_sample, input ready);
    modport sink   (input valid, sample, last_sample, output ready);
endinterface

@@ src/rhb_out_if.sv @@
// Bin report channel interface: valid, ready and bin payload.
// Depends on rhb_pkg.
interface rhb_out_if import rhb_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [IDX_W-1:0]       bin_index;
    logic [COUNT_WIDTH-1:0] bin_total;
    logic                   last_bin;
    modport source (output valid, bin_index, bin_total, last_bin, input ready);
    modport sink   (input valid, bin_index, bin_total, last_bin, output ready);
endinterface

@@ src/range_histogram_binner_unit.sv @@
// Top level of the range histogram binner: config registers, sequencer,
// counter valid bits. Depends on rhb_pkg, rhb_in_if, rhb_out_if,
// rhb_counter_ram, rhb_bin_div.
//
//  channel   dir  handshake        payload
//  i_in      in   valid/ready      sample, last_sample
//  o_out     out  valid/ready      bin_index, bin_total, last_bin
//  i_cfg_*   in   write enable     register index, write data
//
// One sample at a time, as the divider loop and the read/modify/write
// of the counter memory demand: an in-range sample passes accept, IDX_W
// steps of the divider, memory read and write back; an out-of-range
// sample or an empty range skips the divider. Emission passes S_EMIT_RD,
// S_EMIT_LD and S_EMIT_WAIT per bin, waiting out any output stall; o_out
// holds its payload until transferred. Reset (synchronous, active low)
// clears all counter valid bits at once, so no clearing pass is needed.
module range_histogram_binner_unit import rhb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rhb_in_if.sink                i_in,
    rhb_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_RD, S_WR, S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
    } t_state;

    t_state                  r_state;
    logic [SAMPLE_WIDTH-1:0] r_lo, r_hi;
    logic [BC_W-1:0]         r_bc;
    logic [BC_W-1:0]         r_n;
    logic [IDX_W-1:0]        r_bin;
    logic [IDX_W-1:0]        r_i;
    logic                    r_last;
    logic [MAX_BINS-1:0]     r_vld;
    logic                    r_oval;
    logic [IDX_W-1:0]        r_oidx;
    logic [COUNT_WIDTH-1:0]  r_otot;
    logic                    r_olast;

    logic [BC_W-1:0]         n_use;
    logic signed [SAMPLE_WIDTH:0] off;
    logic                    empty, below, above;
    logic                    accept;
    t_div_req                div_req;
    t_div_rsp                div_rsp;
    logic [IDX_W-1:0]        raddr;
    logic [COUNT_WIDTH-1:0]  rdata;
    logic [COUNT_WIDTH-1:0]  cur;
    logic                    we;
    logic [COUNT_WIDTH-1:0]  wdata;
    logic [IDX_W-1:0]        last_idx;

    // bins in use: zero counts as one, clamp at MAX_BINS
    always_comb begin
        if (r_bc == '0) begin
            n_use = BC_W'(1);
        end else if (r_bc > BC_W'(MAX_BINS)) begin
            n_use = BC_W'(MAX_BINS);
        end else begin
            n_use = r_bc;
        end
    end

    assign off   = $signed({i_in.sample[SAMPLE_WIDTH-1], i_in.sample})
                 - $signed({r_lo[SAMPLE_WIDTH-1], r_lo});
    assign empty = ($signed(r_hi) <= $signed(r_lo));
    assign below = ($signed(i_in.sample) < $signed(r_lo));
    assign above = ($signed(i_in.sample) >= $signed(r_hi));

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    assign div_req.start    = accept && !(empty || below || above);
    assign div_req.dividend = DIV_W'(off[SAMPLE_WIDTH-1:0]) * DIV_W'(n_use);
    assign div_req.divisor  = r_hi - r_lo;

    rhb_bin_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign raddr = (r_state == S_EMIT_RD) ? r_i : r_bin;
    assign cur   = r_vld[r_bin] ? rdata : '0;
    assign we    = (r_state == S_WR);
    // saturate at all ones
    assign wdata = (&cur) ? cur : cur + 1'b1;

    rhb_counter_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_bin),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign last_idx = IDX_W'(r_n - 1'b1);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= SAMPLE_WIDTH'(32767);
            r_bc <= BC_W'(MAX_BINS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RANGE_LOW:  r_lo <= i_cfg_data;
                REG_RANGE_HIGH: r_hi <= i_cfg_data;
                REG_BIN_COUNT:  r_bc <= i_cfg_data[BC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_oval  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_n    <= n_use;
                        r_last <= i_in.last_sample;
                        r_i    <= '0;
                        if (empty || below) begin
                            r_bin   <= '0;
                            r_state <= S_RD;
                        end else if (above) begin
                            r_bin   <= IDX_W'(n_use - 1'b1);
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_bin   <= div_rsp.quotient;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_WR;
                S_WR: begin
                    r_vld[r_bin] <= 1'b1;
                    r_state      <= r_last ? S_EMIT_RD : S_IDLE;
                end
                S_EMIT_RD: r_state <= S_EMIT_LD;
                S_EMIT_LD: begin
                    r_oval  <= 1'b1;
                    r_oidx  <= r_i;
                    r_otot  <= r_vld[r_i] ? rdata : '0;
                    r_olast <= (r_i == last_idx);
                    r_state <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT: begin
                    // hold the report until transfer
                    if (o_out.ready) begin
                        r_oval <= 1'b0;
                        if (r_i == last_idx) begin
                            r_vld   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid     = r_oval;
    assign o_out.bin_index = r_oidx;
    assign o_out.bin_total = r_otot;
    assign o_out.last_bin  = r_olast;
endmodule

@@ src/rhb_counter_ram.sv @@
// Bin counter memory: one write port, one read port, registered read data.
// Depends on rhb_pkg.
module rhb_counter_ram import rhb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [IDX_W-1:0]       i_waddr,
    input  logic [COUNT_WIDTH-1:0] i_wdata,
    input  logic [IDX_W-1:0]       i_raddr,
    output logic [COUNT_WIDTH-1:0] o_rdata
);
    logic [COUNT_WIDTH-1:0] r_mem [MAX_BINS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/rhb_bin_div.sv @@
// Restoring divider, one quotient bit per cycle; quotient is known to be
// below MAX_BINS. Depends on rhb_pkg.
module rhb_bin_div import rhb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [DIV_W-1:0]        r_rem;
    logic [SAMPLE_WIDTH-1:0] r_div;
    logic [IDX_W-1:0]        r_q;
    logic [STEP_W-1:0]       r_k;
    logic                    r_busy;
    logic                    r_done;
    logic [DIV_W-1:0]        cand;
    logic                    take;

    assign cand = DIV_W'(r_div) << r_k;
    assign take = (r_rem >= cand);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_q    <= '0;
                r_k    <= STEP_W'(IDX_W - 1);
            end else if (r_busy) begin
                // one quotient bit per step, MSB first
                if (take) begin
                    r_rem <= r_rem - cand;
                end
                r_q[r_k] <= take;
                if (r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;
endmodule

@@ src/rhb_checker.sv @@
// Port-level checker for range_histogram_binner_unit and its bind.
// Depends on rhb_pkg and the top level.
module rhb_checker import rhb_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last
);
    // never take a sample while a report is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("sample ready during report");

    // a stalled report stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("report dropped under stall");

    // more bins follow a non-final report: no sample taken in between
    a_emit_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=> !i_in_ready)
        else $error("emission ended early");

    // a sample without the last flag yields no report right after
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_in_last) |=> !i_out_valid)
        else $error("report without last sample");
endmodule

bind range_histogram_binner_unit rhb_checker u_rhb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_sample),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.last_bin)
);

@@ sim/range_histogram_binner_checker.sv @@
// Checker for the range histogram binner: watches the sample, bin report and
// config ports, predicts the bin reports and compares. Depends on rhb_pkg,
// rhb_in_if, rhb_out_if.
module range_histogram_binner_checker import rhb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rhb_in_if                     i_in,
    rhb_out_if                    i_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [IDX_W-1:0]       bin_index;
        logic [COUNT_WIDTH-1:0] bin_total;
        logic                   last_bin;
    } t_bin_report;

    logic signed [15:0]     low_q;
    logic signed [15:0]     high_q;
    logic [BC_W-1:0]        bins_q;
    logic [COUNT_WIDTH-1:0] counts [MAX_BINS];
    t_bin_report            report_q [$];
    int                     fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = report_q.size();

    function automatic int bins_used(logic [BC_W-1:0] bc);
        if (bc == 0) return 1;
        if (bc > MAX_BINS) return MAX_BINS;
        return int'(bc);
    endfunction

    function automatic int bin_of(logic signed [15:0] s, int n);
        longint lo, hi, b;
        lo = longint'(low_q);
        hi = longint'(high_q);
        if (hi <= lo || longint'(s) < lo) return 0;
        if (longint'(s) >= hi) return n - 1;
        b = ((longint'(s) - lo) * n) / (hi - lo);
        if (b >= n) b = n - 1;
        return int'(b);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (fails < 20)
            $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        int          n, b;
        t_bin_report rep, want;
        if (!i_rst_n) begin
            low_q  <= 16'sd0;
            high_q <= 16'sd32767;
            bins_q <= 7'd64;
            for (int i = 0; i < MAX_BINS; i++) counts[i] = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RANGE_LOW:  low_q  <= i_cfg_data;
                    REG_RANGE_HIGH: high_q <= i_cfg_data;
                    REG_BIN_COUNT:  bins_q <= i_cfg_data[BC_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                n = bins_used(bins_q);
                b = bin_of(i_in.sample, n);
                if (counts[b] != '1) counts[b] = counts[b] + 1;
                if (i_in.last_sample) begin
                    for (int i = 0; i < n; i++) begin
                        rep.bin_index = i[IDX_W-1:0];
                        rep.bin_total = counts[i];
                        rep.last_bin  = (i == n - 1);
                        report_q.push_back(rep);
                    end
                    for (int i = 0; i < MAX_BINS; i++) counts[i] = '0;
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (report_q.size() == 0) begin
                    report_mismatch("unexpected bin report, index", i_out.bin_index, -1);
                end else begin
                    want = report_q.pop_front();
                    if (i_out.bin_index !== want.bin_index)
                        report_mismatch("bin_index", i_out.bin_index, want.bin_index);
                    if (i_out.bin_total !== want.bin_total)
                        report_mismatch("bin_total", i_out.bin_total, want.bin_total);
                    if (i_out.last_bin !== want.last_bin)
                        report_mismatch("last_bin", i_out.last_bin, want.last_bin);
                end
            end
        end
    end
endmodule

@@ sim/range_histogram_binner_unit_tb.sv @@
// Testbench top for range_histogram_binner_unit: clock, reset, stimulus and
// verdict. Depends on rhb_pkg, rhb_in_if, rhb_out_if and the checker.
module range_histogram_binner_unit_tb;
    import rhb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // index with no register behind it; writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    tx_idle_pct;
    int                    rx_idle_pct;
    int                    set_len;
    int                    lo_i, hi_i;

    rhb_in_if  in_ch ();
    rhb_out_if out_ch ();

    range_histogram_binner_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    range_histogram_binner_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: stall at the configured rate, re-decided every cycle.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("range_histogram_binner_unit_tb NOT OK");
        $finish;
    end

    // Present one sample and hold it until transferred. Drop valid only
    // while idling, so valid never toggles within one step.
    task automatic send_sample(logic [15:0] s, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.sample      <= s;
        in_ch.last_sample <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Wait until every bin report is in and any sample still in flight has
    // been counted, so a register write lands on an idle block.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pick a fresh range and bin count; mostly a proper range and few bins.
    task automatic pick_config();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            lo_i = -32768; hi_i = 32767;
        end else if (r < 18) begin
            lo_i = $urandom_range(65535) - 32768; hi_i = lo_i - $urandom_range(40);
            if (hi_i < -32768) hi_i = -32768;
        end else begin
            lo_i = $urandom_range(65535) - 32768;
            hi_i = lo_i + $urandom_range(1, 4000);
            if (hi_i > 32767) hi_i = 32767;
            if (hi_i <= lo_i) begin lo_i = hi_i - 1; end
        end
        cfg_write(REG_RANGE_LOW, lo_i[15:0]);
        cfg_write(REG_RANGE_HIGH, hi_i[15:0]);
        r = $urandom_range(99);
        if (r < 6)       cfg_write(REG_BIN_COUNT, 16'd64);
        else if (r < 9)  cfg_write(REG_BIN_COUNT, {9'($urandom_range(511)), 7'd0});
        else if (r < 12) cfg_write(REG_BIN_COUNT, 16'($urandom_range(65, 127)));
        else             cfg_write(REG_BIN_COUNT,
                                   {9'($urandom), 7'($urandom_range(1, 16))});
        if ($urandom_range(9) == 0) cfg_write(REG_NONE, 16'($urandom));
    endtask

    // Mostly samples inside the range with a few outside and at the bounds.
    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return 16'($urandom);
        if (r < 12) return lo_i[15:0];
        if (r < 16) return hi_i[15:0];
        if (r < 20) return (lo_i > -32768) ? 16'(lo_i - 1) : 16'h8000;
        if (hi_i > lo_i) return 16'(lo_i + $urandom_range(hi_i - lo_i));
        return 16'($urandom);
    endfunction

    initial begin
        tx_idle_pct       = 0;
        rx_idle_pct       = 0;
        lo_i              = 0;
        hi_i              = 32767;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.sample      = '0;
        in_ch.last_sample = 1'b0;
        i_rst_n           = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, sample extremes, below low and at high.
        tx_idle_pct = 18; rx_idle_pct = 78;
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h3FFF, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        settle();
        // Full span, one bin, then two bins with the top bound.
        lo_i = -32768; hi_i = 32767;
        cfg_write(REG_RANGE_LOW, 16'h8000);
        cfg_write(REG_RANGE_HIGH, 16'h7FFF);
        cfg_write(REG_BIN_COUNT, 16'd1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        settle();
        cfg_write(REG_BIN_COUNT, 16'd2);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        settle();
        // Empty range: high equal to low, everything into bin 0.
        lo_i = 100; hi_i = 100;
        cfg_write(REG_RANGE_LOW, 16'd100);
        cfg_write(REG_RANGE_HIGH, 16'd100);
        cfg_write(REG_BIN_COUNT, 16'd8);
        send_sample(16'd100, 1'b0);
        send_sample(16'h8000, 1'b1);
        settle();
        // Zero bins acts as one, oversize count acts as the maximum.
        lo_i = -10; hi_i = 50;
        cfg_write(REG_RANGE_LOW, 16'hFFF6);
        cfg_write(REG_RANGE_HIGH, 16'd50);
        cfg_write(REG_BIN_COUNT, 16'hFF80);
        send_sample(16'd20, 1'b1);
        settle();
        cfg_write(REG_BIN_COUNT, 16'h007F);
        send_sample(16'hFFF5, 1'b0);
        send_sample(16'd49, 1'b1);
        settle();
        // Shrink the bin count mid-set: upper bins are dropped yet cleared.
        cfg_write(REG_BIN_COUNT, 16'd16);
        send_sample(16'd49, 1'b0);
        send_sample(16'd0, 1'b0);
        settle();
        cfg_write(REG_BIN_COUNT, 16'd4);
        cfg_write(REG_NONE, 16'hFFFF);
        send_sample(16'd10, 1'b1);
        settle();
        cfg_write(REG_BIN_COUNT, 16'd16);
        send_sample(16'd0, 1'b1);
        settle();

        // Random sets over the three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 78 : 0;
            rx_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 18 : 0;
            for (int items = 0; items < 84; items += set_len) begin
                if (items == 0 || $urandom_range(2) == 0) begin
                    settle();
                    pick_config();
                end
                set_len = $urandom_range(1, 12);
                for (int k = 0; k < set_len; k++)
                    send_sample(pick_sample(), k == set_len - 1);
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("range_histogram_binner_unit_tb OK");
        end else begin
            $display("range_histogram_binner_unit_tb NOT OK");
        end
        $finish;
    end
endmodule

@@ sim.f @@
src/rhb_pkg.sv
src/rhb_in_if.sv
src/rhb_out_if.sv
src/rhb_counter_ram.sv
src/rhb_bin_div.sv
src/range_histogram_binner_unit.sv
src/rhb_checker.sv
sim/range_histogram_binner_checker.sv
sim/range_histogram_binner_unit_tb.sv
